// File: hdl/lsmt_pkg.sv
`timescale 1ns / 1ps

package lsmt_pkg;

   // Line timing, in dots.
   localparam int unsigned DotsPerCycle = 4;
   localparam int unsigned ScanEnd      = 80;
   localparam int unsigned DrawEnd      = 80 + 289;
   localparam int unsigned LineDots     = 456;
   localparam int unsigned LastVisible  = 143;
   localparam int unsigned LastLine     = 153;

   // Field widths.
   localparam int unsigned CyclesWidth = 4;
   localparam int unsigned DotWidth    = 9;
   localparam int unsigned LineWidth   = 8;
   localparam int unsigned RemWidth    = CyclesWidth + $clog2(DotsPerCycle);
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 8;

   // Register indexes of the configuration port.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_LCD_ENABLE   = 2'd0,
      CSR_COMPARE_LINE = 2'd1,
      CSR_COINC_IRQ_EN = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // Display mode codes as reported in the status register.
   typedef enum logic [1:0] {
      PH_HBLANK = 2'd0,
      PH_VBLANK = 2'd1,
      PH_SCAN   = 2'd2,
      PH_DRAW   = 2'd3
   } phase_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_DELIVER
   } ctrl_state_type;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic                 lcd_enable;
      logic [LineWidth-1:0] compare_line;
      logic                 coinc_irq_enable;
   } cfg_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic load;
   } dp_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic rem_zero;
      logic out_free;
   } dp_status_type;

endpackage

// File: hdl/lsmt_req_if.sv
`timescale 1ns / 1ps

interface lsmt_req_if import lsmt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CyclesWidth-1:0] machine_cycles;

   modport source (output valid, output machine_cycles, input ready);
   modport sink   (input valid, input machine_cycles, output ready);
endinterface

// File: hdl/lsmt_rsp_if.sv
`timescale 1ns / 1ps

interface lsmt_rsp_if import lsmt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LineWidth-1:0] line;
   logic [1:0]           mode;
   logic                 coincidence;
   logic                 scan_done;
   logic                 render_line;
   logic                 vblank_irq;
   logic                 stat_irq;

   modport source (output valid, output line, output mode, output coincidence,
                   output scan_done, output render_line, output vblank_irq,
                   output stat_irq, input ready);
   modport sink   (input valid, input line, input mode, input coincidence,
                   input scan_done, input render_line, input vblank_irq,
                   input stat_irq, output ready);
endinterface

// File: hdl/lsmt_csr_if.sv
`timescale 1ns / 1ps

interface lsmt_csr_if import lsmt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [CsrDatWidth-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/lcd_scanline_mode_timer_core.sv
`timescale 1ns / 1ps

// LCD scanline and mode timer.
// req_chan carries a count of machine cycles; each one advances the dot
// counter by four dots, one dot per clock. rsp_chan returns one result per
// request: current line, mode, coincidence flag and the event pulses
// (end of OAM scan, line render, vblank interrupt, status interrupt) gathered
// over all dots of that request. csr_chan writes the enable, compare line and
// coincidence interrupt enable registers; it is always ready and should be
// used only while no request is in flight.
// A request's dots are stepped in ST_COUNT, once per clock, until the
// remaining count is zero; ST_DELIVER then loads the result into the output
// register. A disabled display or a zero count steps no dot.
// Requests are taken one at a time, so a new request is accepted only after
// the previous result has been loaded; it is accepted while an earlier result
// still waits in the output register.
// Reset restores line 0, OAM scan mode, dot 0 and enabled display.
// When the receiver stalls, the held result stays valid; a finished request
// then waits until the output register frees before the block goes idle.
module lcd_scanline_mode_timer_core import lsmt_pkg::*; (
   input logic       clock,
   input logic       reset,
   lsmt_req_if.sink  req_chan,
   lsmt_rsp_if.source rsp_chan,
   lsmt_csr_if.sink  csr_chan
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers.
   assign csr_chan.ready = 1'b1;

   lsmt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // Sequencer.
   lsmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Timer state and result register.
   lsmt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .machine_cycles  (req_chan.machine_cycles),
      .cmd             (cmd),
      .status          (status),
      .out_ready       (rsp_chan.ready),
      .out_valid       (rsp_chan.valid),
      .out_line        (rsp_chan.line),
      .out_mode        (rsp_chan.mode),
      .out_coincidence (rsp_chan.coincidence),
      .out_scan_done   (rsp_chan.scan_done),
      .out_render_line (rsp_chan.render_line),
      .out_vblank_irq  (rsp_chan.vblank_irq),
      .out_stat_irq    (rsp_chan.stat_irq)
   );

endmodule

// File: hdl/lsmt_csr.sv
`timescale 1ns / 1ps

module lsmt_csr import lsmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_valid,
   input  logic [CsrIdxWidth-1:0] wr_index,
   input  logic [CsrDatWidth-1:0] wr_data,
   output cfg_type                cfg
);

   logic                 lcd_enable_ff;
   logic [LineWidth-1:0] compare_line_ff;
   logic                 coinc_irq_en_ff;

   // Register file; writes to an unknown index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_enable_ff   <= 1'b1;
         compare_line_ff <= '0;
         coinc_irq_en_ff <= 1'b0;
      end else if (wr_valid) begin
         unique case (csr_index_type'(wr_index))
            CSR_LCD_ENABLE:   lcd_enable_ff   <= wr_data[0];
            CSR_COMPARE_LINE: compare_line_ff <= wr_data[LineWidth-1:0];
            CSR_COINC_IRQ_EN: coinc_irq_en_ff <= wr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.lcd_enable       = lcd_enable_ff;
   assign cfg.compare_line     = compare_line_ff;
   assign cfg.coinc_irq_enable = coinc_irq_en_ff;

endmodule

// File: hdl/lsmt_ctrl.sv
`timescale 1ns / 1ps

module lsmt_ctrl import lsmt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (status.rem_zero) begin
               state_in = ST_DELIVER;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DELIVER: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: hdl/lsmt_dp.sv
`timescale 1ns / 1ps

module lsmt_dp import lsmt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic [CyclesWidth-1:0] machine_cycles,
   input  dp_cmd_type             cmd,
   output dp_status_type          status,
   input  logic                   out_ready,
   output logic                   out_valid,
   output logic [LineWidth-1:0]   out_line,
   output logic [1:0]             out_mode,
   output logic                   out_coincidence,
   output logic                   out_scan_done,
   output logic                   out_render_line,
   output logic                   out_vblank_irq,
   output logic                   out_stat_irq
);

   localparam logic [DotWidth-1:0]  ScanEndC     = DotWidth'(ScanEnd);
   localparam logic [DotWidth-1:0]  DrawEndC     = DotWidth'(DrawEnd);
   localparam logic [DotWidth-1:0]  LineDotsC    = DotWidth'(LineDots);
   localparam logic [LineWidth-1:0] LastVisibleC = LineWidth'(LastVisible);
   localparam logic [LineWidth-1:0] LastLineC    = LineWidth'(LastLine);
   localparam int unsigned          ShiftBits    = RemWidth - CyclesWidth;

   // Timer state.
   logic [DotWidth-1:0]  dot_ff, dot_in;
   logic [LineWidth-1:0] line_ff, line_in;
   phase_type            phase_ff, phase_in;
   logic                 irq_prev_ff, irq_prev_in;

   // Per-item counters and event flags.
   logic [RemWidth-1:0]  rem_ff;
   logic                 scan_ff, render_ff, vblank_ff, stat_ff;
   logic                 ev_scan, ev_render, ev_vblank, ev_stat;

   // Output register.
   logic                 out_valid_ff;
   logic [LineWidth-1:0] out_line_ff;
   logic [1:0]           out_mode_ff;
   logic                 out_coinc_ff, out_scan_ff, out_render_ff;
   logic                 out_vblank_ff, out_stat_ff;

   logic [DotWidth-1:0]  dot_inc;
   logic                 level;

   // One dot of the line timer.
   always_comb begin
      dot_inc   = dot_ff + 1'b1;
      dot_in    = dot_inc;
      line_in   = line_ff;
      phase_in  = phase_ff;
      ev_scan   = 1'b0;
      ev_render = 1'b0;
      ev_vblank = 1'b0;
      unique case (phase_ff)
         PH_SCAN: begin
            if (dot_inc >= ScanEndC) begin
               phase_in = PH_DRAW;
               ev_scan  = 1'b1;
            end
         end
         PH_DRAW: begin
            if (dot_inc >= DrawEndC) begin
               phase_in  = PH_HBLANK;
               ev_render = 1'b1;
            end
         end
         PH_HBLANK: begin
            if (dot_inc >= LineDotsC) begin
               dot_in  = '0;
               line_in = line_ff + 1'b1;
               if (line_ff >= LastVisibleC) begin
                  phase_in  = PH_VBLANK;
                  ev_vblank = 1'b1;
               end else begin
                  phase_in = PH_SCAN;
               end
            end
         end
         PH_VBLANK: begin
            if (dot_inc >= LineDotsC) begin
               dot_in = '0;
               if (line_ff >= LastLineC) begin
                  line_in  = '0;
                  phase_in = PH_SCAN;
               end else begin
                  line_in = line_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
      // Status line and its rising edge.
      level       = cfg.coinc_irq_enable && (line_in == cfg.compare_line);
      ev_stat     = level && !irq_prev_ff;
      irq_prev_in = level;
   end

   // Timer state advances one dot per step command.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff      <= '0;
         line_ff     <= '0;
         phase_ff    <= PH_SCAN;
         irq_prev_ff <= 1'b0;
      end else if (cmd.step) begin
         dot_ff      <= dot_in;
         line_ff     <= line_in;
         phase_ff    <= phase_in;
         irq_prev_ff <= irq_prev_in;
      end
   end

   // Dots left in the current item and the events gathered so far.
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         scan_ff   <= 1'b0;
         render_ff <= 1'b0;
         vblank_ff <= 1'b0;
         stat_ff   <= 1'b0;
      end else if (cmd.start) begin
         rem_ff    <= cfg.lcd_enable ? {machine_cycles, ShiftBits'(0)} : '0;
         scan_ff   <= 1'b0;
         render_ff <= 1'b0;
         vblank_ff <= 1'b0;
         stat_ff   <= 1'b0;
      end else if (cmd.step) begin
         rem_ff    <= rem_ff - 1'b1;
         scan_ff   <= scan_ff   | ev_scan;
         render_ff <= render_ff | ev_render;
         vblank_ff <= vblank_ff | ev_vblank;
         stat_ff   <= stat_ff   | ev_stat;
      end
   end

   // Result register; a new result may be loaded as the old one transfers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_line_ff   <= line_ff;
         out_mode_ff   <= phase_ff;
         out_coinc_ff  <= (line_ff == cfg.compare_line);
         out_scan_ff   <= scan_ff;
         out_render_ff <= render_ff;
         out_vblank_ff <= vblank_ff;
         out_stat_ff   <= stat_ff;
      end
   end

   assign status.rem_zero = (rem_ff == '0);
   assign status.out_free = !out_valid_ff || out_ready;

   assign out_valid       = out_valid_ff;
   assign out_line        = out_line_ff;
   assign out_mode        = out_mode_ff;
   assign out_coincidence = out_coinc_ff;
   assign out_scan_done   = out_scan_ff;
   assign out_render_line = out_render_ff;
   assign out_vblank_irq  = out_vblank_ff;
   assign out_stat_irq    = out_stat_ff;

endmodule
